// ===== rtl/tccr_pkg.sv =====
// Shared types, codes, font lookup and pixel packing for the text console cell renderer.
package tccr_pkg;

    localparam int MaxColumns = 256;
    localparam int MaxRows    = 128;
    localparam int ColW       = $clog2(MaxColumns + 1);
    localparam int RowW       = $clog2(MaxRows + 1);
    localparam int QDepth     = 2;
    localparam int QPtrW      = $clog2(QDepth);

    localparam logic [2:0] CFG_ENABLE = 3'd0;
    localparam logic [2:0] CFG_COLS   = 3'd1;
    localparam logic [2:0] CFG_ROWS   = 3'd2;
    localparam logic [2:0] CFG_FMT    = 3'd3;
    localparam logic [2:0] CFG_FG     = 3'd4;
    localparam logic [2:0] CFG_BG     = 3'd5;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_FIRST = 8'h20;
    localparam logic [7:0] CH_LAST  = 8'h7e;
    localparam logic [7:0] CH_QUEST = 8'h3f;

    localparam logic [1:0] FMT_XRGB = 2'd0;
    localparam logic [1:0] FMT_ARGB = 2'd1;
    localparam logic [1:0] FMT_BGRA = 2'd2;
    localparam logic [1:0] FMT_565  = 2'd3;

    typedef enum logic [2:0] {
        OP_NOP, OP_CLEAR, OP_CR, OP_NL, OP_TAB, OP_CHAR
    } t_op;

    typedef enum logic [1:0] {
        K_DRAW = 2'd0, K_SCROLL = 2'd1, K_CLEAR = 2'd2, K_FLUSH = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        B_IDLE, B_CLR1, B_CLR2, B_NL, B_NLF, B_PUT
    } t_bstate;

    typedef logic [4:0][6:0] t_glyph;

    typedef struct packed {
        t_op    op;
        t_glyph glyph;
    } t_entry;

    typedef struct packed {
        logic [ColW-1:0] cols;
        logic [RowW-1:0] rows;
    } t_geom;

    typedef struct packed {
        t_kind  kind;
        logic [7:0] col;
        logic [6:0] row;
        t_glyph glyph;
    } t_res;

    function automatic t_glyph g5(input logic [6:0] a, input logic [6:0] b,
                                  input logic [6:0] c, input logic [6:0] d,
                                  input logic [6:0] e);
        t_glyph g;
        g[0] = a; g[1] = b; g[2] = c; g[3] = d; g[4] = e;
        return g;
    endfunction

    function automatic t_glyph font(input logic [7:0] ch);
        t_glyph g;
        case (ch)
            8'h30: g = g5(7'h3e, 7'h51, 7'h49, 7'h45, 7'h3e);
            8'h31: g = g5(7'h00, 7'h42, 7'h7f, 7'h40, 7'h00);
            8'h32: g = g5(7'h42, 7'h61, 7'h51, 7'h49, 7'h46);
            8'h33: g = g5(7'h21, 7'h41, 7'h45, 7'h4b, 7'h31);
            8'h34: g = g5(7'h18, 7'h14, 7'h12, 7'h7f, 7'h10);
            8'h35: g = g5(7'h27, 7'h45, 7'h45, 7'h45, 7'h39);
            8'h36: g = g5(7'h3c, 7'h4a, 7'h49, 7'h49, 7'h30);
            8'h37: g = g5(7'h01, 7'h71, 7'h09, 7'h05, 7'h03);
            8'h38: g = g5(7'h36, 7'h49, 7'h49, 7'h49, 7'h36);
            8'h39: g = g5(7'h06, 7'h49, 7'h49, 7'h29, 7'h1e);
            8'h41: g = g5(7'h7e, 7'h11, 7'h11, 7'h11, 7'h7e);
            8'h42: g = g5(7'h7f, 7'h49, 7'h49, 7'h49, 7'h36);
            8'h43: g = g5(7'h3e, 7'h41, 7'h41, 7'h41, 7'h22);
            8'h44: g = g5(7'h7f, 7'h41, 7'h41, 7'h22, 7'h1c);
            8'h45: g = g5(7'h7f, 7'h49, 7'h49, 7'h49, 7'h41);
            8'h46: g = g5(7'h7f, 7'h09, 7'h09, 7'h09, 7'h01);
            8'h47: g = g5(7'h3e, 7'h41, 7'h49, 7'h49, 7'h7a);
            8'h48: g = g5(7'h7f, 7'h08, 7'h08, 7'h08, 7'h7f);
            8'h49: g = g5(7'h00, 7'h41, 7'h7f, 7'h41, 7'h00);
            8'h4a: g = g5(7'h20, 7'h40, 7'h41, 7'h3f, 7'h01);
            8'h4b: g = g5(7'h7f, 7'h08, 7'h14, 7'h22, 7'h41);
            8'h4c: g = g5(7'h7f, 7'h40, 7'h40, 7'h40, 7'h40);
            8'h4d: g = g5(7'h7f, 7'h02, 7'h0c, 7'h02, 7'h7f);
            8'h4e: g = g5(7'h7f, 7'h04, 7'h08, 7'h10, 7'h7f);
            8'h4f: g = g5(7'h3e, 7'h41, 7'h41, 7'h41, 7'h3e);
            8'h50: g = g5(7'h7f, 7'h09, 7'h09, 7'h09, 7'h06);
            8'h51: g = g5(7'h3e, 7'h41, 7'h51, 7'h21, 7'h5e);
            8'h52: g = g5(7'h7f, 7'h09, 7'h19, 7'h29, 7'h46);
            8'h53: g = g5(7'h46, 7'h49, 7'h49, 7'h49, 7'h31);
            8'h54: g = g5(7'h01, 7'h01, 7'h7f, 7'h01, 7'h01);
            8'h55: g = g5(7'h3f, 7'h40, 7'h40, 7'h40, 7'h3f);
            8'h56: g = g5(7'h1f, 7'h20, 7'h40, 7'h20, 7'h1f);
            8'h57: g = g5(7'h3f, 7'h40, 7'h38, 7'h40, 7'h3f);
            8'h58: g = g5(7'h63, 7'h14, 7'h08, 7'h14, 7'h63);
            8'h59: g = g5(7'h07, 7'h08, 7'h70, 7'h08, 7'h07);
            8'h5a: g = g5(7'h61, 7'h51, 7'h49, 7'h45, 7'h43);
            8'h20: g = g5(7'h00, 7'h00, 7'h00, 7'h00, 7'h00);
            8'h2e: g = g5(7'h00, 7'h00, 7'h60, 7'h00, 7'h00);
            8'h2c: g = g5(7'h00, 7'h20, 7'h40, 7'h00, 7'h00);
            8'h3a: g = g5(7'h00, 7'h00, 7'h36, 7'h00, 7'h00);
            8'h3b: g = g5(7'h00, 7'h20, 7'h46, 7'h00, 7'h00);
            8'h2d: g = g5(7'h00, 7'h08, 7'h08, 7'h08, 7'h00);
            8'h5f: g = g5(7'h40, 7'h40, 7'h40, 7'h40, 7'h40);
            8'h2f: g = g5(7'h20, 7'h10, 7'h08, 7'h04, 7'h02);
            8'h5c: g = g5(7'h02, 7'h04, 7'h08, 7'h10, 7'h20);
            8'h3e: g = g5(7'h00, 7'h41, 7'h22, 7'h14, 7'h08);
            8'h3c: g = g5(7'h08, 7'h14, 7'h22, 7'h41, 7'h00);
            8'h3d: g = g5(7'h00, 7'h14, 7'h14, 7'h14, 7'h00);
            8'h2b: g = g5(7'h00, 7'h08, 7'h3e, 7'h08, 7'h00);
            8'h21: g = g5(7'h00, 7'h00, 7'h5f, 7'h00, 7'h00);
            8'h3f: g = g5(7'h02, 7'h01, 7'h51, 7'h09, 7'h06);
            8'h5b: g = g5(7'h00, 7'h7f, 7'h41, 7'h00, 7'h00);
            8'h5d: g = g5(7'h00, 7'h00, 7'h41, 7'h7f, 7'h00);
            8'h28: g = g5(7'h41, 7'h22, 7'h1c, 7'h00, 7'h00);
            8'h29: g = g5(7'h00, 7'h00, 7'h1c, 7'h22, 7'h41);
            8'h23: g = g5(7'h14, 7'h7f, 7'h14, 7'h7f, 7'h14);
            default: g = g5(7'h7f, 7'h41, 7'h41, 7'h41, 7'h7f);
        endcase
        return g;
    endfunction

    function automatic logic [31:0] pack_pixel(input logic [1:0] fmt,
                                               input logic [23:0] rgb);
        logic [31:0] w;
        case (fmt)
            FMT_565:  w = {16'h0000, rgb[23:19], rgb[15:10], rgb[7:3]};
            FMT_BGRA: w = {8'hff, rgb[7:0], rgb[15:8], rgb[23:16]};
            FMT_ARGB: w = {8'hff, rgb};
            default:  w = {8'h00, rgb};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/tccr_if.sv =====
// Valid/ready channel interfaces for commands in and cell results out.
interface tccr_cmd_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] char_code;
    modport source (output valid, command, char_code, input ready);
    modport sink   (input valid, command, char_code, output ready);
endinterface

interface tccr_cell_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  cell_column;
    logic [6:0]  cell_row;
    logic [6:0]  glyph_col0;
    logic [6:0]  glyph_col1;
    logic [6:0]  glyph_col2;
    logic [6:0]  glyph_col3;
    logic [6:0]  glyph_col4;
    logic [31:0] fg_pixel;
    logic [31:0] bg_pixel;
    logic        last;
    modport source (output valid, kind, cell_column, cell_row, glyph_col0, glyph_col1,
                    glyph_col2, glyph_col3, glyph_col4, fg_pixel, bg_pixel, last,
                    input ready);
    modport sink   (input valid, kind, cell_column, cell_row, glyph_col0, glyph_col1,
                    glyph_col2, glyph_col3, glyph_col4, fg_pixel, bg_pixel, last,
                    output ready);
endinterface

// ===== rtl/tccr_front.sv =====
// Command intake: classify, fold and look up glyph, then queue for the sequencer.
module tccr_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_enabled,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic            i_command,
    input  logic [7:0]      i_char_code,
    output logic            o_q_valid,
    output tccr_pkg::t_entry o_q_entry,
    input  logic            i_q_pop
);
    tccr_pkg::t_entry r_q [tccr_pkg::QDepth];
    logic [tccr_pkg::QPtrW-1:0] r_wr, r_rd;
    logic [tccr_pkg::QPtrW:0]   r_cnt;
    tccr_pkg::t_entry w_ent;
    logic [7:0]       w_ch;
    logic             w_push;

    always_comb begin
        w_ch = i_char_code;
        if (w_ch < tccr_pkg::CH_FIRST || w_ch > tccr_pkg::CH_LAST) begin
            w_ch = tccr_pkg::CH_QUEST;
        end else if (w_ch >= 8'h61 && w_ch <= 8'h7a) begin
            w_ch = w_ch - 8'h20;
        end
        w_ent.glyph = tccr_pkg::font(w_ch);
        if (i_command) begin
            w_ent.op = tccr_pkg::OP_CLEAR;
        end else if (!i_enabled) begin
            w_ent.op = tccr_pkg::OP_NOP;
        end else if (i_char_code == tccr_pkg::CH_CR) begin
            w_ent.op = tccr_pkg::OP_CR;
        end else if (i_char_code == tccr_pkg::CH_LF) begin
            w_ent.op = tccr_pkg::OP_NL;
        end else if (i_char_code == tccr_pkg::CH_TAB) begin
            w_ent.op    = tccr_pkg::OP_TAB;
            w_ent.glyph = '0;
        end else begin
            w_ent.op = tccr_pkg::OP_CHAR;
        end
    end

    assign o_ready   = (r_cnt != (tccr_pkg::QPtrW+1)'(tccr_pkg::QDepth));
    assign w_push    = i_valid && o_ready;
    assign o_q_valid = (r_cnt != '0);
    assign o_q_entry = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_q_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (tccr_pkg::QPtrW+1)'(w_push)
                           - (tccr_pkg::QPtrW+1)'(i_q_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_ent;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && !i_q_pop && r_cnt == (tccr_pkg::QPtrW+1)'(tccr_pkg::QDepth)))
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> r_cnt != '0)
        else $error("queue underflow");
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == (tccr_pkg::QPtrW+1)'(tccr_pkg::QDepth) |-> !o_ready)
        else $error("ready while full");
endmodule

// ===== rtl/tccr_back.sv =====
// Cursor sequencer: executes queued ops and emits cell results through hold and output registers.
module tccr_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tccr_pkg::t_geom  i_geom,
    input  logic             i_q_valid,
    input  tccr_pkg::t_entry i_q_entry,
    output logic             o_q_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output tccr_pkg::t_res   o_res,
    output logic             o_last
);
    tccr_pkg::t_bstate r_state, n_state;
    tccr_pkg::t_op     r_op, n_op;
    tccr_pkg::t_glyph  r_glyph, n_glyph;
    logic [tccr_pkg::ColW-1:0] r_col, n_col;
    logic [7:0]        r_row, n_row;
    tccr_pkg::t_res    r_hold, r_out, w_res;
    logic              r_hold_valid, r_out_valid, r_out_last;
    logic              w_out_free, w_en, w_prod;
    logic [7:0]        w_nl_row, w_rows;
    logic              w_scroll, w_wrap;
    logic [tccr_pkg::ColW-1:0] w_col_inc;

    assign w_out_free = !r_out_valid || i_ready;
    assign w_en       = !r_hold_valid || w_out_free;
    assign w_rows     = 8'(i_geom.rows);
    assign w_nl_row   = r_row + 8'd1;
    assign w_scroll   = (w_nl_row >= w_rows);
    assign w_wrap     = (r_col >= i_geom.cols);
    assign w_col_inc  = r_col + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tccr_pkg::B_IDLE;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_glyph <= n_glyph;
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_glyph = r_glyph;
        n_col   = r_col;
        n_row   = r_row;
        o_q_pop = 1'b0;
        w_prod  = 1'b0;
        w_res   = '0;
        case (r_state)
            tccr_pkg::B_IDLE: begin
                if (i_q_valid && w_en) begin
                    o_q_pop = 1'b1;
                    n_op    = i_q_entry.op;
                    n_glyph = i_q_entry.glyph;
                    case (i_q_entry.op)
                        tccr_pkg::OP_CLEAR: n_state = tccr_pkg::B_CLR1;
                        tccr_pkg::OP_CR:    n_col   = '0;
                        tccr_pkg::OP_NL:    n_state = tccr_pkg::B_NL;
                        tccr_pkg::OP_TAB:   n_state = tccr_pkg::B_PUT;
                        tccr_pkg::OP_CHAR:  n_state = tccr_pkg::B_PUT;
                        default:            n_state = tccr_pkg::B_IDLE;
                    endcase
                end
            end
            tccr_pkg::B_CLR1: begin
                if (w_en) begin
                    w_prod     = 1'b1;
                    w_res.kind = tccr_pkg::K_CLEAR;
                    n_state    = tccr_pkg::B_CLR2;
                end
            end
            tccr_pkg::B_CLR2: begin
                if (w_en) begin
                    w_prod     = 1'b1;
                    w_res.kind = tccr_pkg::K_FLUSH;
                    n_col      = '0;
                    n_row      = '0;
                    n_state    = tccr_pkg::B_IDLE;
                end
            end
            tccr_pkg::B_NL: begin
                if (w_en) begin
                    n_col = '0;
                    n_row = w_scroll ? r_row : w_nl_row;
                    if (w_scroll) begin
                        w_prod     = 1'b1;
                        w_res.kind = tccr_pkg::K_SCROLL;
                    end
                    n_state = tccr_pkg::B_NLF;
                end
            end
            tccr_pkg::B_NLF: begin
                if (w_en) begin
                    w_prod     = 1'b1;
                    w_res.kind = tccr_pkg::K_FLUSH;
                    n_state    = tccr_pkg::B_IDLE;
                end
            end
            tccr_pkg::B_PUT: begin
                if (w_en) begin
                    if (w_wrap) begin
                        n_col = '0;
                        n_row = w_scroll ? r_row : w_nl_row;
                        if (w_scroll) begin
                            w_prod     = 1'b1;
                            w_res.kind = tccr_pkg::K_SCROLL;
                        end
                    end else begin
                        if (r_row < w_rows) begin
                            w_prod      = 1'b1;
                            w_res.kind  = tccr_pkg::K_DRAW;
                            w_res.col   = r_col[7:0];
                            w_res.row   = r_row[6:0];
                            w_res.glyph = r_glyph;
                        end
                        n_col = w_col_inc;
                        if (!(r_op == tccr_pkg::OP_TAB && w_col_inc[1:0] != 2'd0)) begin
                            n_state = tccr_pkg::B_IDLE;
                        end
                    end
                end
            end
            default: n_state = tccr_pkg::B_IDLE;
        endcase
    end

    // Hold the newest result until the next one or the end of the item sets its last flag.
    logic w_load_last, w_load_mid;
    assign w_load_last = (r_state == tccr_pkg::B_IDLE) && r_hold_valid && w_out_free;
    assign w_load_mid  = (r_state != tccr_pkg::B_IDLE) && w_en && w_prod && r_hold_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_load_last || w_load_mid) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_prod) begin
                r_hold_valid <= 1'b1;
            end else if (w_load_last) begin
                r_hold_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_last || w_load_mid) begin
            r_out      <= r_hold;
            r_out_last <= w_load_last;
        end
        if (w_prod) begin
            r_hold <= w_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;
    assign o_last  = r_out_last;

    a_hold_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hold_valid && !w_out_free) |=> r_hold_valid && $stable(r_hold))
        else $error("held result lost under stall");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> r_state == tccr_pkg::B_IDLE)
        else $error("pop while busy");
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid && !r_hold_valid)
        else $error("output valid after reset");
endmodule

// ===== rtl/text_console_cell_renderer.sv =====
// Top level: configuration registers, pixel packing and channel wiring of the console renderer.
//   channel | dir | payload                                      | transfer
//   i_cmd   | in  | command, char_code                           | valid && ready
//   o_cell  | out | kind, cell_column, cell_row, glyph_col0..4,  | valid && ready
//           |     | fg_pixel, bg_pixel, last                     |
//   cfg     | in  | i_cfg_idx, i_cfg_data                        | i_cfg_we
// The sequencer picks each item up from the queue and then works it: a line wrap adds a
// cursor step before the character is drawn, and a tab draws blank cells until the column
// is a multiple of four. The two-entry command queue lets intake run ahead of the sequencer.
// Results leave through a hold register and an output register, so a stalled sink holds the
// sequencer only once both are full. Reset is synchronous and clears cursor and queue.
module text_console_cell_renderer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tccr_cmd_if.sink     i_cmd,
    tccr_cell_if.source  o_cell,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [23:0]  i_cfg_data
);
    logic        r_enabled;
    logic [8:0]  r_cols;
    logic [7:0]  r_rows;
    logic [1:0]  r_fmt;
    logic [23:0] r_fg, r_bg;

    tccr_pkg::t_geom  w_geom;
    tccr_pkg::t_entry w_q_entry;
    tccr_pkg::t_res   w_res;
    logic             w_q_valid, w_q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b0;
            r_cols    <= 9'd80;
            r_rows    <= 8'd25;
            r_fmt     <= tccr_pkg::FMT_XRGB;
            r_fg      <= 24'he8e8e8;
            r_bg      <= 24'h101820;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tccr_pkg::CFG_ENABLE: r_enabled <= i_cfg_data[0];
                tccr_pkg::CFG_COLS:   r_cols    <= i_cfg_data[8:0];
                tccr_pkg::CFG_ROWS:   r_rows    <= i_cfg_data[7:0];
                tccr_pkg::CFG_FMT:    r_fmt     <= i_cfg_data[1:0];
                tccr_pkg::CFG_FG:     r_fg      <= i_cfg_data;
                tccr_pkg::CFG_BG:     r_bg      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_cols < 9'd4) begin
            w_geom.cols = tccr_pkg::ColW'(4);
        end else if (tccr_pkg::ColW'(r_cols) > tccr_pkg::ColW'(tccr_pkg::MaxColumns)) begin
            w_geom.cols = tccr_pkg::ColW'(tccr_pkg::MaxColumns);
        end else begin
            w_geom.cols = tccr_pkg::ColW'(r_cols);
        end
        if (r_rows == 8'd0) begin
            w_geom.rows = tccr_pkg::RowW'(1);
        end else if (tccr_pkg::RowW'(r_rows) > tccr_pkg::RowW'(tccr_pkg::MaxRows)) begin
            w_geom.rows = tccr_pkg::RowW'(tccr_pkg::MaxRows);
        end else begin
            w_geom.rows = tccr_pkg::RowW'(r_rows);
        end
    end

    tccr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_enabled   (r_enabled),
        .i_valid     (i_cmd.valid),
        .o_ready     (i_cmd.ready),
        .i_command   (i_cmd.command),
        .i_char_code (i_cmd.char_code),
        .o_q_valid   (w_q_valid),
        .o_q_entry   (w_q_entry),
        .i_q_pop     (w_q_pop)
    );

    tccr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_geom    (w_geom),
        .i_q_valid (w_q_valid),
        .i_q_entry (w_q_entry),
        .o_q_pop   (w_q_pop),
        .o_valid   (o_cell.valid),
        .i_ready   (o_cell.ready),
        .o_res     (w_res),
        .o_last    (o_cell.last)
    );

    assign o_cell.kind        = w_res.kind;
    assign o_cell.cell_column = w_res.col;
    assign o_cell.cell_row    = w_res.row;
    assign o_cell.glyph_col0  = w_res.glyph[0];
    assign o_cell.glyph_col1  = w_res.glyph[1];
    assign o_cell.glyph_col2  = w_res.glyph[2];
    assign o_cell.glyph_col3  = w_res.glyph[3];
    assign o_cell.glyph_col4  = w_res.glyph[4];
    assign o_cell.fg_pixel    = tccr_pkg::pack_pixel(r_fmt, r_fg);
    assign o_cell.bg_pixel    = tccr_pkg::pack_pixel(r_fmt, r_bg);
endmodule

// ===== verif/tccr_tb_pkg.sv =====
// Scoreboard class and expected-cell predictor for the text console cell renderer.
package tccr_tb_pkg;
    import tccr_pkg::*;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  col;
        logic [6:0]  row;
        logic [6:0]  g [5];
        logic [31:0] fg;
        logic [31:0] bg;
        logic        last;
    } t_cell;

    class cell_scoreboard;
        logic        enabled;
        logic [8:0]  cols;
        logic [7:0]  rows;
        logic [1:0]  fmt;
        logic [23:0] fg_rgb;
        logic [23:0] bg_rgb;
        logic [8:0]  cur_col;
        logic [7:0]  cur_row;
        int          errors;
        t_cell       pending[$];
        int          eff_cols, eff_rows;
        logic [31:0] fg_w, bg_w;
        int          n_new;

        function new();
            enabled = 0; cols = 80; rows = 25; fmt = FMT_XRGB;
            fg_rgb = 24'he8e8e8; bg_rgb = 24'h101820;
            cur_col = 0; cur_row = 0; errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [23:0] v);
            case (idx)
                CFG_ENABLE: enabled = v[0];
                CFG_COLS:   cols = v[8:0];
                CFG_ROWS:   rows = v[7:0];
                CFG_FMT:    fmt = v[1:0];
                CFG_FG:     fg_rgb = v;
                CFG_BG:     bg_rgb = v;
                default: ;
            endcase
        endfunction

        function logic [31:0] packed_word(logic [23:0] c);
            case (fmt)
                FMT_565:  return {16'h0, c[23:19], c[15:10], c[7:3]};
                FMT_BGRA: return {8'hff, c[7:0], c[15:8], c[23:16]};
                FMT_ARGB: return {8'hff, c};
                default:  return {8'h00, c};
            endcase
        endfunction

        function void glyph_of(logic [7:0] ch, output logic [6:0] g [5]);
            logic [34:0] v;
            if (ch >= 8'h61 && ch <= 8'h7a) ch = ch - 8'h20;
            case (ch)
                8'h30: v = {7'h3e, 7'h51, 7'h49, 7'h45, 7'h3e};
                8'h31: v = {7'h00, 7'h42, 7'h7f, 7'h40, 7'h00};
                8'h32: v = {7'h42, 7'h61, 7'h51, 7'h49, 7'h46};
                8'h33: v = {7'h21, 7'h41, 7'h45, 7'h4b, 7'h31};
                8'h34: v = {7'h18, 7'h14, 7'h12, 7'h7f, 7'h10};
                8'h35: v = {7'h27, 7'h45, 7'h45, 7'h45, 7'h39};
                8'h36: v = {7'h3c, 7'h4a, 7'h49, 7'h49, 7'h30};
                8'h37: v = {7'h01, 7'h71, 7'h09, 7'h05, 7'h03};
                8'h38: v = {7'h36, 7'h49, 7'h49, 7'h49, 7'h36};
                8'h39: v = {7'h06, 7'h49, 7'h49, 7'h29, 7'h1e};
                8'h41: v = {7'h7e, 7'h11, 7'h11, 7'h11, 7'h7e};
                8'h42: v = {7'h7f, 7'h49, 7'h49, 7'h49, 7'h36};
                8'h43: v = {7'h3e, 7'h41, 7'h41, 7'h41, 7'h22};
                8'h44: v = {7'h7f, 7'h41, 7'h41, 7'h22, 7'h1c};
                8'h45: v = {7'h7f, 7'h49, 7'h49, 7'h49, 7'h41};
                8'h46: v = {7'h7f, 7'h09, 7'h09, 7'h09, 7'h01};
                8'h47: v = {7'h3e, 7'h41, 7'h49, 7'h49, 7'h7a};
                8'h48: v = {7'h7f, 7'h08, 7'h08, 7'h08, 7'h7f};
                8'h49: v = {7'h00, 7'h41, 7'h7f, 7'h41, 7'h00};
                8'h4a: v = {7'h20, 7'h40, 7'h41, 7'h3f, 7'h01};
                8'h4b: v = {7'h7f, 7'h08, 7'h14, 7'h22, 7'h41};
                8'h4c: v = {7'h7f, 7'h40, 7'h40, 7'h40, 7'h40};
                8'h4d: v = {7'h7f, 7'h02, 7'h0c, 7'h02, 7'h7f};
                8'h4e: v = {7'h7f, 7'h04, 7'h08, 7'h10, 7'h7f};
                8'h4f: v = {7'h3e, 7'h41, 7'h41, 7'h41, 7'h3e};
                8'h50: v = {7'h7f, 7'h09, 7'h09, 7'h09, 7'h06};
                8'h51: v = {7'h3e, 7'h41, 7'h51, 7'h21, 7'h5e};
                8'h52: v = {7'h7f, 7'h09, 7'h19, 7'h29, 7'h46};
                8'h53: v = {7'h46, 7'h49, 7'h49, 7'h49, 7'h31};
                8'h54: v = {7'h01, 7'h01, 7'h7f, 7'h01, 7'h01};
                8'h55: v = {7'h3f, 7'h40, 7'h40, 7'h40, 7'h3f};
                8'h56: v = {7'h1f, 7'h20, 7'h40, 7'h20, 7'h1f};
                8'h57: v = {7'h3f, 7'h40, 7'h38, 7'h40, 7'h3f};
                8'h58: v = {7'h63, 7'h14, 7'h08, 7'h14, 7'h63};
                8'h59: v = {7'h07, 7'h08, 7'h70, 7'h08, 7'h07};
                8'h5a: v = {7'h61, 7'h51, 7'h49, 7'h45, 7'h43};
                8'h20: v = 35'h0;
                8'h2e: v = {7'h00, 7'h00, 7'h60, 7'h00, 7'h00};
                8'h2c: v = {7'h00, 7'h20, 7'h40, 7'h00, 7'h00};
                8'h3a: v = {7'h00, 7'h00, 7'h36, 7'h00, 7'h00};
                8'h3b: v = {7'h00, 7'h20, 7'h46, 7'h00, 7'h00};
                8'h2d: v = {7'h00, 7'h08, 7'h08, 7'h08, 7'h00};
                8'h5f: v = {7'h40, 7'h40, 7'h40, 7'h40, 7'h40};
                8'h2f: v = {7'h20, 7'h10, 7'h08, 7'h04, 7'h02};
                8'h5c: v = {7'h02, 7'h04, 7'h08, 7'h10, 7'h20};
                8'h3e: v = {7'h00, 7'h41, 7'h22, 7'h14, 7'h08};
                8'h3c: v = {7'h08, 7'h14, 7'h22, 7'h41, 7'h00};
                8'h3d: v = {7'h00, 7'h14, 7'h14, 7'h14, 7'h00};
                8'h2b: v = {7'h00, 7'h08, 7'h3e, 7'h08, 7'h00};
                8'h21: v = {7'h00, 7'h00, 7'h5f, 7'h00, 7'h00};
                8'h3f: v = {7'h02, 7'h01, 7'h51, 7'h09, 7'h06};
                8'h5b: v = {7'h00, 7'h7f, 7'h41, 7'h00, 7'h00};
                8'h5d: v = {7'h00, 7'h00, 7'h41, 7'h7f, 7'h00};
                8'h28: v = {7'h41, 7'h22, 7'h1c, 7'h00, 7'h00};
                8'h29: v = {7'h00, 7'h00, 7'h1c, 7'h22, 7'h41};
                8'h23: v = {7'h14, 7'h7f, 7'h14, 7'h7f, 7'h14};
                default: v = {7'h7f, 7'h41, 7'h41, 7'h41, 7'h7f};
            endcase
            for (int i = 0; i < 5; i++) g[i] = v[34 - 7*i -: 7];
        endfunction

        function void push_cell(logic [1:0] k, int c, int r, logic [7:0] ch, bit has_glyph);
            t_cell e;
            if (n_new >= 8) return;
            e.kind = k; e.col = c[7:0]; e.row = r[6:0];
            if (has_glyph) glyph_of(ch, e.g);
            else for (int i = 0; i < 5; i++) e.g[i] = '0;
            e.fg = fg_w; e.bg = bg_w; e.last = 0;
            pending.push_back(e);
            n_new++;
        endfunction

        function void advance_row();
            cur_col = 0;
            cur_row = cur_row + 1;
            if (cur_row >= eff_rows) begin
                push_cell(K_SCROLL, 0, 0, 0, 0);
                if (cur_row != 0) cur_row--;
            end
        endfunction

        function void place_char(logic [7:0] ch);
            if (ch < CH_FIRST || ch > CH_LAST) ch = CH_QUEST;
            if (cur_col >= eff_cols) advance_row();
            if (cur_row < eff_rows) push_cell(K_DRAW, cur_col, cur_row, ch, 1);
            cur_col = cur_col + 1;
        endfunction

        function void note_command(logic cmd, logic [7:0] ch);
            n_new = 0;
            eff_cols = cols < 4 ? 4 : (cols > MaxColumns ? MaxColumns : cols);
            eff_rows = rows < 1 ? 1 : (rows > MaxRows ? MaxRows : rows);
            fg_w = packed_word(fg_rgb);
            bg_w = packed_word(bg_rgb);
            if (cmd) begin
                push_cell(K_CLEAR, 0, 0, 0, 0);
                push_cell(K_FLUSH, 0, 0, 0, 0);
                cur_col = 0; cur_row = 0;
            end else if (enabled) begin
                if (ch == CH_CR) cur_col = 0;
                else if (ch == CH_LF) begin
                    advance_row();
                    push_cell(K_FLUSH, 0, 0, 0, 0);
                end else if (ch == CH_TAB) begin
                    do place_char(CH_FIRST); while (cur_col[1:0] != 0);
                end else place_char(ch);
            end
            if (n_new > 0) pending[$].last = 1;
        endfunction

        function void check_cell(t_cell a);
            t_cell e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected cell kind=%0d col=%0d row=%0d", $time,
                         a.kind, a.col, a.row);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.kind !== e.kind) begin
                $display("%0t: kind exp %0d got %0d", $time, e.kind, a.kind); errors++;
            end
            if (a.col !== e.col) begin
                $display("%0t: cell_column exp %0d got %0d", $time, e.col, a.col); errors++;
            end
            if (a.row !== e.row) begin
                $display("%0t: cell_row exp %0d got %0d", $time, e.row, a.row); errors++;
            end
            for (int i = 0; i < 5; i++)
                if (a.g[i] !== e.g[i]) begin
                    $display("%0t: glyph_col%0d exp %h got %h", $time, i, e.g[i], a.g[i]);
                    errors++;
                end
            if (a.fg !== e.fg) begin
                $display("%0t: fg_pixel exp %h got %h", $time, e.fg, a.fg); errors++;
            end
            if (a.bg !== e.bg) begin
                $display("%0t: bg_pixel exp %h got %h", $time, e.bg, a.bg); errors++;
            end
            if (a.last !== e.last) begin
                $display("%0t: last exp %0d got %0d", $time, e.last, a.last); errors++;
            end
        endfunction
    endclass
endpackage

// ===== verif/testbench.sv =====
// Top-level testbench: drives commands and register writes, checks every emitted cell.
module testbench;
    import tccr_pkg::*;
    import tccr_tb_pkg::*;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [2:0]  i_cfg_idx = '0;
    logic [23:0] i_cfg_data = '0;
    int          quiet_cycles = 0;
    bit          done = 0;

    tccr_cmd_if  cmd_ch();
    tccr_cell_if cell_ch();

    cell_scoreboard sb = new();

    initial begin
        cmd_ch.valid = 0; cmd_ch.command = 0; cmd_ch.char_code = 0; cell_ch.ready = 0;
    end

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    text_console_cell_renderer u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd_ch.sink), .o_cell(cell_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    always @(posedge i_clk) begin
        t_cell a;
        if (i_rst_n && cell_ch.valid && cell_ch.ready) begin
            a.kind = cell_ch.kind; a.col = cell_ch.cell_column; a.row = cell_ch.cell_row;
            a.g[0] = cell_ch.glyph_col0; a.g[1] = cell_ch.glyph_col1;
            a.g[2] = cell_ch.glyph_col2; a.g[3] = cell_ch.glyph_col3;
            a.g[4] = cell_ch.glyph_col4;
            a.fg = cell_ch.fg_pixel; a.bg = cell_ch.bg_pixel; a.last = cell_ch.last;
            sb.check_cell(a);
        end
        if (i_rst_n && cmd_ch.valid && cmd_ch.ready)
            sb.note_command(cmd_ch.command, cmd_ch.char_code);
    end

    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (cell_ch.valid && cell_ch.ready)
            || !i_rst_n || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 3000) begin
            $display("** text_console_cell_renderer: FAILED **");
            $finish;
        end
    end

    initial begin
        int n;
        @(posedge i_clk);
        while (!done) begin
            n = gap_len();
            if ($urandom_range(0, 9) < 3) n = 0;
            cell_ch.ready <= (n == 0);
            if (n == 0) n = $urandom_range(1, 6);
            repeat (n) @(posedge i_clk);
            if (cell_ch.ready == 0) begin
                cell_ch.ready <= 1;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
        end
    end

    task automatic send(logic cmd, logic [7:0] ch);
        cmd_ch.valid <= 1; cmd_ch.command <= cmd; cmd_ch.char_code <= ch;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        if (gap_len() > 0) begin
            cmd_ch.valid <= 0;
            repeat (gap_len() + 1) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [23:0] v);
        cmd_ch.valid <= 0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.write_reg(idx, v);
    endtask

    function automatic logic [7:0] rand_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 8'($urandom_range(8'h20, 8'h7e));
        if (r < 65) return CH_LF;
        if (r < 72) return CH_TAB;
        if (r < 77) return CH_CR;
        return 8'($urandom_range(0, 255));
    endfunction

    initial begin
        logic [7:0] directed [] = '{8'h41, 8'h7a, 8'h30, 8'h39, 8'h20, 8'h7e, 8'h7f,
                                    8'h00, 8'hff, 8'h80, 8'h5c, 8'h23, 8'h3f, CH_TAB,
                                    CH_CR, CH_LF, 8'h61};
        int cols_set [] = '{4, 256, 511, 0, 7, 13};
        int rows_set [] = '{1, 128, 255, 0, 3, 2};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        send(1'b0, 8'h41);
        write_reg(CFG_ENABLE, 24'd1);
        foreach (directed[i]) send(1'b0, directed[i]);
        send(1'b1, 8'hff);
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_COLS, 24'(cols_set[ph]));
            write_reg(CFG_ROWS, 24'(rows_set[ph]));
            write_reg(CFG_FMT, 24'(ph % 4));
            write_reg(CFG_FG, ph == 0 ? 24'hffffff : (ph == 1 ? 24'h0 : 24'($urandom())));
            write_reg(CFG_BG, ph == 0 ? 24'h0 : (ph == 1 ? 24'hffffff : 24'($urandom())));
            if (ph == 4) write_reg(CFG_ENABLE, 24'd0);
            if (ph == 5) write_reg(CFG_ENABLE, 24'd1);
            for (int k = 0; k < 52; k++)
                send($urandom_range(0, 39) == 0, rand_char());
        end
        write_reg(CFG_ROWS, 24'd1);
        for (int k = 0; k < 10; k++) send(1'b0, rand_char());
        cmd_ch.valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        done = 1;
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("** text_console_cell_renderer: PASSED **");
        else
            $display("** text_console_cell_renderer: FAILED **");
        $finish;
    end
endmodule
